// File: hdl/flrh_pkg.sv
// ----------------------------------------------------------------------------
// flrh_pkg
// Types and constants shared by the framed link receiver blocks.
// ----------------------------------------------------------------------------
package flrh_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned STEP_W      = 4;
	localparam logic [7:0]  SYNC_LEN    = 8'd4;

	typedef enum logic [2:0] {
		REG_MAGIC    = 3'd0,
		REG_SYNC     = 3'd1,
		REG_SYNC_ACK = 3'd2,
		REG_BEAT     = 3'd3,
		REG_BEAT_ACK = 3'd4,
		REG_REV      = 3'd5,
		REG_INTERVAL = 3'd6,
		REG_MAX_MISS = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_TX      = 2'd2,
		KIND_DISC    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CMD_PAYLOAD = 3'd0,
		CMD_EMPTY   = 3'd1,
		CMD_DISC    = 3'd2,
		CMD_SYNC    = 3'd3,
		CMD_BEAT    = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic [31:0] magic_value;
		logic [7:0]  sync_code;
		logic [7:0]  sync_ack_code;
		logic [7:0]  heartbeat_code;
		logic [7:0]  heartbeat_ack_code;
		logic [31:0] revision_word;
		logic [15:0] heartbeat_interval_ms;
		logic [7:0]  max_missed;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t   cmd;
		logic [7:0]  msg_type;
		logic [7:0]  data;
		logic [15:0] index;
		logic        last;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  msg_type;
		logic [7:0]  data;
		logic [15:0] index;
		logic        last;
	} res_t;

	// byte i of a word, counted from the least significant byte
	function automatic logic [7:0] sel_byte(input logic [31:0] w, input logic [1:0] i);
		return w[{i, 3'b000} +: 8];
	endfunction

endpackage

// File: hdl/framed_link_receiver_with_heartbeat_core.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_with_heartbeat_core
// Sync-word framed receiver with link supervision and heartbeat transmit.
// ----------------------------------------------------------------------------
// Each received byte (op 0) gives at most one result; a supervise request
// (op 1) may yield up to SYNC_BYTES+7 transmit results, which leave at one
// per cycle while out_stall is low. The front part takes a request every
// cycle while its four-entry command queue has room; the output register
// drains the queue, so a long transmit run stalls input only once the queue
// fills. Configuration is read live by both parts.
module framed_link_receiver_with_heartbeat_core
	import flrh_pkg::*;
#(
	parameter int unsigned SYNC_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  msg_type,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic        last
);

	cfg_t cfg;
	logic push, q_full, pop, head_valid;
	cmd_t push_cmd, head_cmd;

	flrh_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	flrh_front #(.SYNC_BYTES(SYNC_BYTES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op      (op),
		.rx_byte (rx_byte),
		.now_ms  (now_ms),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	flrh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	flrh_back #(.SYNC_BYTES(SYNC_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.msg_type  (msg_type),
		.data_byte (data_byte),
		.byte_index(byte_index),
		.last      (last)
	);

endmodule

// File: hdl/flrh_cfg.sv
// ----------------------------------------------------------------------------
// flrh_cfg
// APB register file holding the link configuration.
// ----------------------------------------------------------------------------
module flrh_cfg
	import flrh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_value           <= 32'd0;
			cfg_q.sync_code             <= 8'd0;
			cfg_q.sync_ack_code         <= 8'd1;
			cfg_q.heartbeat_code        <= 8'd2;
			cfg_q.heartbeat_ack_code    <= 8'd3;
			cfg_q.revision_word         <= 32'd0;
			cfg_q.heartbeat_interval_ms <= 16'd500;
			cfg_q.max_missed            <= 8'd10;
		end else if (wr) begin
			unique case (idx)
				REG_MAGIC:    cfg_q.magic_value           <= pwdata;
				REG_SYNC:     cfg_q.sync_code             <= pwdata[7:0];
				REG_SYNC_ACK: cfg_q.sync_ack_code         <= pwdata[7:0];
				REG_BEAT:     cfg_q.heartbeat_code        <= pwdata[7:0];
				REG_BEAT_ACK: cfg_q.heartbeat_ack_code    <= pwdata[7:0];
				REG_REV:      cfg_q.revision_word         <= pwdata;
				REG_INTERVAL: cfg_q.heartbeat_interval_ms <= pwdata[15:0];
				REG_MAX_MISS: cfg_q.max_missed            <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAGIC:    prdata = cfg_q.magic_value;
			REG_SYNC:     prdata = {24'd0, cfg_q.sync_code};
			REG_SYNC_ACK: prdata = {24'd0, cfg_q.sync_ack_code};
			REG_BEAT:     prdata = {24'd0, cfg_q.heartbeat_code};
			REG_BEAT_ACK: prdata = {24'd0, cfg_q.heartbeat_ack_code};
			REG_REV:      prdata = cfg_q.revision_word;
			REG_INTERVAL: prdata = {16'd0, cfg_q.heartbeat_interval_ms};
			REG_MAX_MISS: prdata = {24'd0, cfg_q.max_missed};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// File: hdl/flrh_front.sv
// ----------------------------------------------------------------------------
// flrh_front
// Accepts requests, tracks framing and link state, issues output commands.
// ----------------------------------------------------------------------------
module flrh_front
	import flrh_pkg::*;
#(
	parameter int unsigned SYNC_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	localparam int unsigned MP_W = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
	localparam logic [MP_W-1:0] MP_LAST = MP_W'(SYNC_BYTES - 1);

	phase_t          phase_q, phase_d;
	logic [MP_W-1:0] mp_q, mp_d;
	logic [1:0]      hdr_cnt_q, hdr_cnt_d;
	logic [7:0]      type_q, type_d;
	logic [15:0]     len_q, len_d;
	logic [15:0]     pc_q, pc_d;
	logic            fwd_q, fwd_d;
	logic            link_q, link_d;
	logic [8:0]      miss_q, miss_d;
	logic [31:0]     beat_q, beat_d;

	logic        accept;
	logic        byte_in;
	logic        sup_in;
	logic [15:0] len_full;
	logic        fin;
	logic        fwd_new;
	logic        match_hit;
	logic [31:0] due;
	logic        beat_due;

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign byte_in   = accept && !op;
	assign sup_in    = accept && op;
	assign len_full  = {len_q[15:8], rx_byte};
	assign fin       = ({1'b0, pc_q} + 17'd1) >= {1'b0, len_q};
	assign fwd_new   = link_q || (type_q == cfg.sync_ack_code);
	assign match_hit = rx_byte == sel_byte(cfg.magic_value,
		2'(SYNC_BYTES - 1 - int'(mp_q)));
	assign due       = beat_q + {16'd0, cfg.heartbeat_interval_ms};
	assign beat_due  = (now_ms > due) || (beat_q == 32'd0);

	always_comb begin
		phase_d = phase_q;
		if (byte_in) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q == 2'd2)
						phase_d = (len_full == 16'd0) ? PH_HUNT : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (fin)
						phase_d = PH_HUNT;
				end
				default: begin
					phase_d = (match_hit && mp_q == MP_LAST) ? PH_HEADER : PH_HUNT;
				end
			endcase
		end
	end

	always_comb begin
		mp_d      = mp_q;
		hdr_cnt_d = hdr_cnt_q;
		type_d    = type_q;
		len_d     = len_q;
		pc_d      = pc_q;
		fwd_d     = fwd_q;
		link_d    = link_q;
		miss_d    = miss_q;
		beat_d    = beat_q;
		push      = 1'b0;
		push_cmd  = '{cmd: CMD_PAYLOAD, msg_type: type_q, data: rx_byte,
			index: pc_q, last: fin};
		if (byte_in) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q == 2'd0) begin
						type_d    = rx_byte;
						hdr_cnt_d = 2'd1;
					end else if (hdr_cnt_q == 2'd1) begin
						len_d     = {rx_byte, 8'd0};
						hdr_cnt_d = 2'd2;
					end else begin
						len_d     = len_full;
						hdr_cnt_d = 2'd0;
						fwd_d     = fwd_new;
						pc_d      = 16'd0;
						if (len_full == 16'd0) begin
							mp_d = '0;
							if (fwd_new) begin
								push         = 1'b1;
								push_cmd.cmd = CMD_EMPTY;
								if (type_q == cfg.sync_ack_code)
									link_d = 1'b1;
								if (type_q == cfg.heartbeat_ack_code)
									miss_d = 9'd0;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					push = fwd_q;
					pc_d = pc_q + 16'd1;
					if (fin) begin
						mp_d = '0;
						if (fwd_q && type_q == cfg.sync_ack_code)
							link_d = 1'b1;
						if (fwd_q && type_q == cfg.heartbeat_ack_code)
							miss_d = 9'd0;
					end
				end
				default: begin
					if (match_hit && mp_q != MP_LAST) begin
						mp_d = mp_q + MP_W'(1);
					end else begin
						mp_d = '0;
						if (match_hit)
							hdr_cnt_d = 2'd0;
					end
				end
			endcase
		end else if (sup_in) begin
			if (!link_q) begin
				push         = 1'b1;
				push_cmd.cmd = CMD_SYNC;
			end else if (miss_q > {1'b0, cfg.max_missed}) begin
				miss_d       = 9'd0;
				link_d       = 1'b0;
				push         = 1'b1;
				push_cmd.cmd = CMD_DISC;
			end else if (beat_due) begin
				push         = 1'b1;
				push_cmd.cmd = CMD_BEAT;
				beat_d       = now_ms;
				if (miss_q != 9'h1ff)
					miss_d = miss_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			mp_q      <= '0;
			hdr_cnt_q <= 2'd0;
			type_q    <= 8'd0;
			len_q     <= 16'd0;
			pc_q      <= 16'd0;
			fwd_q     <= 1'b0;
			link_q    <= 1'b0;
			miss_q    <= 9'd0;
			beat_q    <= 32'd0;
		end else begin
			phase_q   <= phase_d;
			mp_q      <= mp_d;
			hdr_cnt_q <= hdr_cnt_d;
			type_q    <= type_d;
			len_q     <= len_d;
			pc_q      <= pc_d;
			fwd_q     <= fwd_d;
			link_q    <= link_d;
			miss_q    <= miss_d;
			beat_q    <= beat_d;
		end
	end

endmodule

// File: hdl/flrh_queue.sv
// ----------------------------------------------------------------------------
// flrh_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module flrh_queue
	import flrh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
		end
	end

endmodule

// File: hdl/flrh_back.sv
// ----------------------------------------------------------------------------
// flrh_back
// Expands queued commands into result requests behind an output register.
// ----------------------------------------------------------------------------
module flrh_back
	import flrh_pkg::*;
#(
	parameter int unsigned SYNC_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  msg_type,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic        last
);

	localparam logic [STEP_W-1:0] S_CODE     = STEP_W'(SYNC_BYTES);
	localparam logic [STEP_W-1:0] S_LEN_HI   = STEP_W'(SYNC_BYTES + 1);
	localparam logic [STEP_W-1:0] S_LEN_LO   = STEP_W'(SYNC_BYTES + 2);
	localparam logic [STEP_W-1:0] S_SYNC_END = STEP_W'(SYNC_BYTES + 6);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	res_t              res_q;
	res_t              res;
	logic              done;
	logic              load;
	logic [7:0]        word_byte;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = head_valid && load && done;
	assign word_byte = sel_byte(cfg.magic_value, 2'(SYNC_BYTES - 1 - int'(step_q)));

	always_comb begin
		res  = '{kind: KIND_TX, msg_type: 8'd0, data: 8'd0, index: 16'd0, last: 1'b0};
		done = 1'b1;
		unique case (head_cmd.cmd)
			CMD_PAYLOAD: begin
				res.kind     = KIND_PAYLOAD;
				res.msg_type = head_cmd.msg_type;
				res.data     = head_cmd.data;
				res.index    = head_cmd.index;
				res.last     = head_cmd.last;
			end
			CMD_EMPTY: begin
				res.kind     = KIND_EMPTY;
				res.msg_type = head_cmd.msg_type;
				res.last     = 1'b1;
			end
			CMD_DISC: begin
				res.kind = KIND_DISC;
				res.last = 1'b1;
			end
			CMD_SYNC: begin
				done     = step_q == S_SYNC_END;
				res.last = done;
				if (step_q < S_CODE)
					res.data = word_byte;
				else if (step_q == S_CODE)
					res.data = cfg.sync_code;
				else if (step_q == S_LEN_HI)
					res.data = 8'd0;
				else if (step_q == S_LEN_LO)
					res.data = SYNC_LEN;
				else
					res.data = sel_byte(cfg.revision_word,
						2'(SYNC_BYTES + 6 - int'(step_q)));
			end
			CMD_BEAT: begin
				done     = step_q == S_LEN_LO;
				res.last = done;
				if (step_q < S_CODE)
					res.data = word_byte;
				else if (step_q == S_CODE)
					res.data = cfg.heartbeat_code;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && head_valid)
			res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				step_q <= done ? '0 : step_q + STEP_W'(1);
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = res_q.kind;
	assign msg_type   = res_q.msg_type;
	assign data_byte  = res_q.data;
	assign byte_index = res_q.index;
	assign last       = res_q.last;

endmodule

// File: hdl/flrh_checker.sv
// ----------------------------------------------------------------------------
// flrh_checker
// Port-level checks on the result stream of the framed link receiver.
// ----------------------------------------------------------------------------
module flrh_checker
	import flrh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [7:0]  msg_type,
	input logic [7:0]  data_byte,
	input logic [15:0] byte_index,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(msg_type) && $stable(byte_index) && $stable(last))
		else $error("stalled result changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_EMPTY || kind == KIND_DISC) |-> last && data_byte == 8'd0)
		else $error("empty frame or disconnect not a single final result");

	a_tx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_TX || kind == KIND_DISC)
			|-> msg_type == 8'd0 && byte_index == 16'd0)
		else $error("transmit or disconnect carries frame fields");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == KIND_EMPTY |-> byte_index == 16'd0)
		else $error("empty frame carries an index");

endmodule

bind framed_link_receiver_with_heartbeat_core flrh_checker u_flrh_checker (.*);

// File: tb/framed_link_receiver_with_heartbeat_core_tb.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_with_heartbeat_core_tb
// Self-checking regression for the framed link receiver core.
// ----------------------------------------------------------------------------
// Sends received bytes and supervise requests, keeps a shadow of the frame
// parser and link state to work out the receive and transmit results, and
// compares every result the core hands out, in order. A directed part covers
// the sync word rules, the supervise branches and the heartbeat boundary; then
// random frame traffic runs under several register settings and idle/stall
// mixes.
// ----------------------------------------------------------------------------
module framed_link_receiver_with_heartbeat_core_tb
	import flrh_pkg::*;
;

	localparam int unsigned N_SYNC        = 4;
	localparam int unsigned HDR_BYTES     = N_SYNC + 3;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TRAFFIC_ITEMS = 25;

	class link_tracker;
		logic [31:0] magic;
		logic [7:0]  sync_code;
		logic [7:0]  link_ack;
		logic [7:0]  beat_code;
		logic [7:0]  beat_ack;
		logic [31:0] revision;
		logic [15:0] interval;
		logic [7:0]  max_miss;

		phase_t      phase;
		logic [2:0]  progress;
		logic [1:0]  hdr_cnt;
		logic [7:0]  ftype;
		logic [15:0] flen;
		logic [15:0] pcount;
		logic        fwd;
		logic        link_up;
		logic [8:0]  missed;
		logic [31:0] last_beat;

		res_t        due_results[$];
		int          errors;

		function new();
			magic     = '0;
			sync_code = 8'd0;
			link_ack  = 8'd1;
			beat_code = 8'd2;
			beat_ack  = 8'd3;
			revision  = '0;
			interval  = 16'd500;
			max_miss  = 8'd10;
			phase     = PH_HUNT;
			progress  = '0;
			hdr_cnt   = '0;
			ftype     = '0;
			flen      = '0;
			pcount    = '0;
			fwd       = 1'b0;
			link_up   = 1'b0;
			missed    = '0;
			last_beat = '0;
			errors    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_MAGIC:    magic     = val;
				REG_SYNC:     sync_code = val[7:0];
				REG_SYNC_ACK: link_ack  = val[7:0];
				REG_BEAT:     beat_code = val[7:0];
				REG_BEAT_ACK: beat_ack  = val[7:0];
				REG_REV:      revision  = val;
				REG_INTERVAL: interval  = val[15:0];
				default:      max_miss  = val[7:0];
			endcase
		endfunction

		function logic [7:0] sync_byte(int unsigned i);
			return 8'(magic >> (8 * (N_SYNC - 1 - i)));
		endfunction

		function void push(kind_t k, logic [7:0] t, logic [7:0] d, logic [15:0] idx, logic l);
			res_t r;
			r.kind     = k;
			r.msg_type = t;
			r.data     = d;
			r.index    = idx;
			r.last     = l;
			due_results.push_back(r);
		endfunction

		function void push_tx(logic [7:0] d, logic l);
			push(KIND_TX, 8'd0, d, 16'd0, l);
		endfunction

		function void push_sync_word();
			for (int i = 0; i < N_SYNC; i++)
				push_tx(sync_byte(i), 1'b0);
		endfunction

		function void close_frame();
			if (fwd) begin
				if (ftype == link_ack)
					link_up = 1'b1;
				if (ftype == beat_ack)
					missed = '0;
			end
			phase    = PH_HUNT;
			progress = '0;
		endfunction

		function void take_request(logic o, logic [7:0] b, logic [31:0] now);
			logic [31:0] due;
			logic        fin;
			if (!o) begin
				case (phase)
					PH_HEADER: begin
						if (hdr_cnt == 2'd0) begin
							ftype   = b;
							hdr_cnt = 2'd1;
						end else if (hdr_cnt == 2'd1) begin
							flen    = {b, 8'h00};
							hdr_cnt = 2'd2;
						end else begin
							flen[7:0] = b;
							hdr_cnt   = 2'd0;
							fwd       = link_up || ftype == link_ack;
							pcount    = '0;
							if (flen == 16'd0) begin
								if (fwd)
									push(KIND_EMPTY, ftype, 8'd0, 16'd0, 1'b1);
								close_frame();
							end else begin
								phase = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						fin = (17'(pcount) + 17'd1) >= 17'(flen);
						if (fwd)
							push(KIND_PAYLOAD, ftype, b, pcount, fin);
						pcount++;
						if (fin)
							close_frame();
					end
					default: begin
						phase = PH_HUNT;
						if (progress >= N_SYNC)
							progress = '0;
						if (b == sync_byte(progress)) begin
							progress++;
							if (progress == N_SYNC) begin
								progress = '0;
								phase    = PH_HEADER;
								hdr_cnt  = '0;
							end
						end else begin
							progress = '0;
						end
					end
				endcase
			end else if (!link_up) begin
				push_sync_word();
				push_tx(sync_code, 1'b0);
				push_tx(8'd0, 1'b0);
				push_tx(SYNC_LEN, 1'b0);
				push_tx(revision[31:24], 1'b0);
				push_tx(revision[23:16], 1'b0);
				push_tx(revision[15:8], 1'b0);
				push_tx(revision[7:0], 1'b1);
			end else if (missed > 9'(max_miss)) begin
				missed  = '0;
				link_up = 1'b0;
				push(KIND_DISC, 8'd0, 8'd0, 16'd0, 1'b1);
			end else begin
				due = last_beat + 32'(interval);
				if (now > due || last_beat == 32'd0) begin
					push_sync_word();
					push_tx(beat_code, 1'b0);
					push_tx(8'd0, 1'b0);
					push_tx(8'd0, 1'b1);
					if (missed < 9'd511)
						missed++;
					last_beat = now;
				end
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d type %02h data %02h index %0d last %0b",
					got.kind, got.msg_type, got.data, got.index, got.last));
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
					got.data !== want.data || got.index !== want.index ||
					got.last !== want.last) begin
					report($sformatf({"expected kind %0d type %02h data %02h index %0d last %0b, ",
						"got kind %0d type %02h data %02h index %0d last %0b"},
						want.kind, want.msg_type, want.data, want.index, want.last,
						got.kind, got.msg_type, got.data, got.index, got.last));
				end
			end
		endfunction
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [4:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        op         = 1'b0;
	logic [7:0]  rx_byte    = '0;
	logic [31:0] now_ms     = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  msg_type;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic        last;

	link_tracker sb;
	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;
	int unsigned items_sent = 0;
	logic [31:0] clock_ms   = '0;

	framed_link_receiver_with_heartbeat_core #(.SYNC_BYTES(N_SYNC)) u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind     = kind_t'(kind);
			got.msg_type = msg_type;
			got.data     = data_byte;
			got.index    = byte_index;
			got.last     = last;
			sb.check_result(got);
		end
	end

	// all tasks start and end at a falling edge with nothing yet driven there
	task automatic push_request(input logic o, input logic [7:0] b, input logic [31:0] t);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		rx_byte  <= b;
		now_ms   <= t;
		do @(posedge clk); while (in_stall);
		sb.take_request(o, b, t);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_rx(input logic [7:0] b);
		push_request(1'b0, b, $urandom);
	endtask

	task automatic supervise_at(input logic [31:0] t);
		push_request(1'b1, 8'($urandom), t);
	endtask

	task automatic supervise_rand();
		if ($urandom_range(0, 3) == 0)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, 2 * sb.interval + 2);
		supervise_at(clock_ms);
	endtask

	task automatic send_frame(input logic [7:0] t, input logic [15:0] len, input bit mix);
		logic [7:0] hdr [HDR_BYTES];
		for (int i = 0; i < N_SYNC; i++)
			hdr[i] = sb.sync_byte(i);
		hdr[N_SYNC]     = t;
		hdr[N_SYNC + 1] = len[15:8];
		hdr[N_SYNC + 2] = len[7:0];
		for (int j = 0; j < HDR_BYTES + len; j++) begin
			if (mix && $urandom_range(0, 99) < 8)
				supervise_rand();
			send_rx((j < HDR_BYTES) ? hdr[j] : 8'($urandom));
		end
	endtask

	// partial sync word cut off by a wrong byte
	task automatic send_broken();
		int unsigned n;
		logic [7:0]  b;
		n = $urandom_range(1, N_SYNC - 1);
		for (int i = 0; i < n; i++)
			send_rx(sb.sync_byte(i));
		do b = 8'($urandom); while (b == sb.sync_byte(n));
		send_rx(b);
	endtask

	task automatic send_noise();
		logic [7:0] b;
		do b = 8'($urandom); while (b == sb.sync_byte(0));
		send_rx(b);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int m);
		logic [31:0] v [8];
		case (m)
			0: begin
				v = '{32'hFFFF_FFFF, 32'h00, 32'hFF, 32'hFF, 32'h00, 32'hFFFF_FFFF, 32'h0, 32'hFF};
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				v = '{$urandom, 32'hFF, 32'h00, 32'h00, 32'hFF, 32'h0, 32'hFFFF, 32'h0};
				idle_pct  = 70;
				stall_pct = 0;
			end
			default: begin
				v[0] = $urandom;
				for (int i = 1; i < 5; i++)
					v[i] = $urandom_range(0, 255);
				v[5] = $urandom;
				v[6] = $urandom_range(0, 2000);
				v[7] = $urandom_range(0, 4);
				idle_pct  = (m == 2) ? 0 : 14;
				stall_pct = (m == 2) ? 70 : 14;
			end
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), v[i]);
	endtask

	task automatic run_traffic(input int unsigned n);
		int unsigned start;
		int unsigned pick;
		logic [7:0]  t;
		logic [15:0] len;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 2))
					0:       t = sb.link_ack;
					1:       t = sb.beat_ack;
					default: t = 8'($urandom);
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 15)
					len = 16'd0;
				else if (pick < 95)
					len = 16'($urandom_range(1, 6));
				else
					len = 16'($urandom_range(7, 40));
				send_frame(t, len, 1'b1);
			end else if (pick < 72) begin
				supervise_rand();
			end else if (pick < 86) begin
				send_broken();
			end else if (pick < 97) begin
				send_noise();
			end else begin
				settle();
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: sync while down, sync-ack empty frame, heartbeat interval edge
		supervise_at(32'd0);
		send_frame(8'h01, 16'd0, 1'b0);
		supervise_at(32'd100);
		supervise_at(32'd600);
		supervise_at(32'd601);
		settle();

		write_reg(REG_MAGIC, 32'h1111_1122);
		write_reg(REG_SYNC, 32'h5A);
		write_reg(REG_BEAT_ACK, 32'hFF);
		write_reg(REG_REV, 32'hA5C3_0F81);
		write_reg(REG_MAX_MISS, 32'h0);
		// mismatching byte must not restart the match
		for (int i = 0; i < 6; i++)
			send_rx(8'h11);
		send_rx(8'h22);
		send_frame(8'hFF, 16'd1, 1'b0);
		supervise_at(32'hFFFF_FFFF);
		supervise_at(32'd5);
		supervise_at(32'd7);
		settle();

		for (int m = 0; m < 4; m++) begin
			configure(m);
			run_traffic(TRAFFIC_ITEMS);
			settle();
		end

		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
		if (sb.errors == 0)
			$display("framed_link_receiver_with_heartbeat_core regression: pass");
		else
			$display("framed_link_receiver_with_heartbeat_core regression: fail");
		$finish;
	end

	initial begin
		#24_000_000;
		$display("framed_link_receiver_with_heartbeat_core regression: fail");
		$finish;
	end

endmodule
